// ===== design/vt_escape_sequence_parser_assert.svh =====
// Assertion macros used by the VT escape sequence parser controller.
`ifndef VT_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define VT_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define VTESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define VTESC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/vtesc_pkg.sv =====
// Package with the constants, codes and control types of the VT escape sequence parser.
`timescale 1ns / 1ps

package vtesc_pkg;

  localparam int unsigned MaxParams = 16;
  localparam int unsigned IdxW      = $clog2(MaxParams);
  localparam int unsigned CntW      = $clog2(MaxParams + 1);
  localparam int unsigned KindW     = 3;

  localparam logic [KindW-1:0] KIND_TEXT = 3'd0;
  localparam logic [KindW-1:0] KIND_ESC  = 3'd1;
  localparam logic [KindW-1:0] KIND_CSI  = 3'd2;
  localparam logic [KindW-1:0] KIND_HASH = 3'd3;
  localparam logic [KindW-1:0] KIND_CSET = 3'd4;

  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_VT       = 8'd11;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_HASH     = "#";
  localparam logic [7:0] CH_QUEST    = "?";
  localparam logic [7:0] CH_SEMI     = ";";
  localparam logic [7:0] CH_ZERO     = "0";
  localparam logic [7:0] CH_NINE     = "9";
  localparam logic [7:0] CH_LPAREN   = "(";
  localparam logic [7:0] CH_RPAREN   = ")";
  localparam logic [7:0] CH_PLUS     = "+";
  localparam logic [7:0] CH_STAR     = "*";
  localparam logic [7:0] CH_LC_C     = "c";
  localparam logic [7:0] CH_THREE    = "3";
  localparam logic [7:0] CH_FOUR     = "4";
  localparam logic [7:0] CH_FIVE     = "5";
  localparam logic [7:0] CH_SIX      = "6";
  localparam logic [7:0] CH_SEVEN    = "7";
  localparam logic [7:0] CH_EIGHT    = "8";
  localparam logic [7:0] CH_UC_D     = "D";
  localparam logic [7:0] CH_UC_E     = "E";
  localparam logic [7:0] CH_UC_H     = "H";
  localparam logic [7:0] CH_UC_I     = "I";
  localparam logic [7:0] CH_UC_J     = "J";
  localparam logic [7:0] CH_UC_K     = "K";
  localparam logic [7:0] CH_UC_M     = "M";

  typedef struct packed {
    logic             load_simple;
    logic [KindW-1:0] simple_kind;
    logic             csi_open;
    logic             set_intro;
    logic             digit;
    logic             next_param;
    logic             close_param;
    logic             emit_read;
    logic             emit_push;
  } vtesc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic params_full;
    logic cset_intro;
    logic emit_last;
  } vtesc_sts_t;

endpackage

// ===== design/vtesc_if.sv =====
// Item channel interfaces for received bytes and parsed events.
`timescale 1ns / 1ps

interface vtesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface vtesc_out_if;
  logic                       valid;
  logic                       ready;
  logic [vtesc_pkg::KindW-1:0] kind;
  logic [7:0]                 code;
  logic [7:0]                 intro;
  logic [vtesc_pkg::CntW-1:0] param_count;
  logic [vtesc_pkg::IdxW-1:0] param_index;
  logic [7:0]                 param_value;
  logic                       last;

  modport source (
    output valid, output kind, output code, output intro, output param_count,
    output param_index, output param_value, output last, input ready
  );
  modport sink (
    input valid, input kind, input code, input intro, input param_count,
    input param_index, input param_value, input last, output ready
  );
endinterface

// ===== design/vtesc_datapath.sv =====
// Datapath: intro, parameter count and memory, digit accumulator and output register.
`timescale 1ns / 1ps

module vtesc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  ch_i,
  input  vtesc_pkg::vtesc_cmd_t       cmd_i,
  output vtesc_pkg::vtesc_sts_t       sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [vtesc_pkg::KindW-1:0] kind_o,
  output logic [7:0]                  code_o,
  output logic [7:0]                  intro_o,
  output logic [vtesc_pkg::CntW-1:0]  param_count_o,
  output logic [vtesc_pkg::IdxW-1:0]  param_index_o,
  output logic [7:0]                  param_value_o,
  output logic                        last_o
);

  logic [7:0]                 intro_q, intro_d;
  logic [vtesc_pkg::CntW-1:0] count_q, count_d;
  logic [7:0]                 cur_q, cur_d;
  logic [7:0]                 final_q;
  logic [vtesc_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0]                 rd_q;
  logic [7:0]                 mem_q [vtesc_pkg::MaxParams];
  logic                       out_valid_q, out_valid_d;
  logic [vtesc_pkg::CntW-1:0] wr_ptr;
  logic                       out_load;

  assign wr_ptr   = count_q - vtesc_pkg::CntW'(1);
  assign out_load = cmd_i.load_simple | cmd_i.emit_push;

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.params_full = (count_q == vtesc_pkg::CntW'(vtesc_pkg::MaxParams));
  assign sts_o.cset_intro  = (intro_q == vtesc_pkg::CH_LPAREN) ||
                             (intro_q == vtesc_pkg::CH_RPAREN);
  assign sts_o.emit_last   = ((vtesc_pkg::CntW'(idx_q) + vtesc_pkg::CntW'(1)) == count_q);

  always_comb begin
    intro_d = intro_q;
    count_d = count_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    if (cmd_i.csi_open) begin
      intro_d = '0;
      count_d = vtesc_pkg::CntW'(1);
      cur_d   = '0;
    end
    if (cmd_i.set_intro) begin
      intro_d = ch_i;
    end
    if (cmd_i.digit) begin
      cur_d = (cur_q << 3) + (cur_q << 1) + (ch_i - vtesc_pkg::CH_ZERO);
    end
    if (cmd_i.next_param) begin
      count_d = count_q + vtesc_pkg::CntW'(1);
      cur_d   = '0;
    end
    if (cmd_i.close_param) begin
      idx_d = '0;
    end
    if (cmd_i.emit_push) begin
      idx_d = idx_q + vtesc_pkg::IdxW'(1);
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intro_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      intro_q     <= intro_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.next_param || cmd_i.close_param) begin
      mem_q[wr_ptr[vtesc_pkg::IdxW-1:0]] <= cur_q;
    end
    if (cmd_i.close_param) begin
      final_q <= ch_i;
    end
    if (cmd_i.emit_read) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_push) begin
      kind_o        <= vtesc_pkg::KIND_CSI;
      code_o        <= final_q;
      intro_o       <= intro_q;
      param_count_o <= count_q;
      param_index_o <= idx_q;
      param_value_o <= rd_q;
      last_o        <= sts_o.emit_last;
    end else if (cmd_i.load_simple) begin
      kind_o        <= cmd_i.simple_kind;
      code_o        <= ch_i;
      intro_o       <= (cmd_i.simple_kind == vtesc_pkg::KIND_CSET) ? intro_q : 8'd0;
      param_count_o <= '0;
      param_index_o <= '0;
      param_value_o <= '0;
      last_o        <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/vtesc_controller.sv =====
// Controller: parser mode state machine and sequencing of CSI parameter output.
`timescale 1ns / 1ps

`include "vt_escape_sequence_parser_assert.svh"

module vtesc_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            ch_i,
  output logic                  in_ready_o,
  input  vtesc_pkg::vtesc_sts_t sts_i,
  output vtesc_pkg::vtesc_cmd_t cmd_o
);

  localparam logic [2:0] ST_NORMAL    = 3'd0;
  localparam logic [2:0] ST_ESC       = 3'd1;
  localparam logic [2:0] ST_CSI_START = 3'd2;
  localparam logic [2:0] ST_CSI_PARAM = 3'd3;
  localparam logic [2:0] ST_HASH      = 3'd4;
  localparam logic [2:0] ST_READCHAR  = 3'd5;
  localparam logic [2:0] ST_EMIT_RD   = 3'd6;
  localparam logic [2:0] ST_EMIT_PUSH = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;
  logic       is_digit;

  assign in_ready_o = (state_q != ST_EMIT_RD) && (state_q != ST_EMIT_PUSH) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (ch_i >= vtesc_pkg::CH_ZERO) && (ch_i <= vtesc_pkg::CH_NINE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_EMIT_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d         = ST_EMIT_PUSH;
      end
      ST_EMIT_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_push = 1'b1;
          state_d         = sts_i.emit_last ? ST_NORMAL : ST_EMIT_RD;
        end
      end
      default: begin
        if (!accept) begin
          state_d = state_q;
        end else if ((state_q != ST_NORMAL) && ((ch_i == vtesc_pkg::CH_BS) ||
                     (ch_i == vtesc_pkg::CH_LF) || (ch_i == vtesc_pkg::CH_CR))) begin
          cmd_o.load_simple = 1'b1;
          cmd_o.simple_kind = vtesc_pkg::KIND_TEXT;
        end else if ((state_q != ST_NORMAL) && (ch_i == vtesc_pkg::CH_VT)) begin
          state_d = ST_READCHAR;
        end else begin
          unique case (state_q)
            ST_ESC: begin
              state_d = ST_NORMAL;
              unique case (ch_i)
                vtesc_pkg::CH_LBRACKET: begin
                  cmd_o.csi_open = 1'b1;
                  state_d        = ST_CSI_START;
                end
                vtesc_pkg::CH_HASH: begin
                  state_d = ST_HASH;
                end
                vtesc_pkg::CH_ESC: begin
                  cmd_o.load_simple = 1'b1;
                  cmd_o.simple_kind = vtesc_pkg::KIND_TEXT;
                end
                vtesc_pkg::CH_LC_C, vtesc_pkg::CH_SEVEN, vtesc_pkg::CH_EIGHT,
                vtesc_pkg::CH_UC_H, vtesc_pkg::CH_UC_J, vtesc_pkg::CH_UC_K,
                vtesc_pkg::CH_UC_D, vtesc_pkg::CH_UC_E, vtesc_pkg::CH_UC_I,
                vtesc_pkg::CH_UC_M: begin
                  cmd_o.load_simple = 1'b1;
                  cmd_o.simple_kind = vtesc_pkg::KIND_ESC;
                end
                vtesc_pkg::CH_LPAREN, vtesc_pkg::CH_RPAREN, vtesc_pkg::CH_PLUS,
                vtesc_pkg::CH_STAR: begin
                  cmd_o.set_intro = 1'b1;
                  state_d         = ST_READCHAR;
                end
                default: begin
                  state_d = ST_NORMAL;
                end
              endcase
            end
            ST_CSI_START, ST_CSI_PARAM: begin
              if (is_digit) begin
                cmd_o.digit = 1'b1;
                state_d     = ST_CSI_PARAM;
              end else if (ch_i == vtesc_pkg::CH_SEMI) begin
                cmd_o.next_param = 1'b1;
                state_d          = sts_i.params_full ? ST_NORMAL : ST_CSI_PARAM;
              end else if ((state_q == ST_CSI_START) && ((ch_i == vtesc_pkg::CH_QUEST) ||
                           (ch_i == vtesc_pkg::CH_HASH))) begin
                cmd_o.set_intro = 1'b1;
                state_d         = ST_CSI_PARAM;
              end else begin
                cmd_o.close_param = 1'b1;
                state_d           = ST_EMIT_RD;
              end
            end
            ST_HASH: begin
              state_d = ST_NORMAL;
              if ((ch_i == vtesc_pkg::CH_THREE) || (ch_i == vtesc_pkg::CH_FOUR) ||
                  (ch_i == vtesc_pkg::CH_FIVE) || (ch_i == vtesc_pkg::CH_SIX) ||
                  (ch_i == vtesc_pkg::CH_EIGHT)) begin
                cmd_o.load_simple = 1'b1;
                cmd_o.simple_kind = vtesc_pkg::KIND_HASH;
              end
            end
            ST_READCHAR: begin
              state_d = ST_NORMAL;
              if (sts_i.cset_intro) begin
                cmd_o.load_simple = 1'b1;
                cmd_o.simple_kind = vtesc_pkg::KIND_CSET;
              end
            end
            default: begin
              if (ch_i == vtesc_pkg::CH_ESC) begin
                state_d = ST_ESC;
              end else begin
                state_d           = ST_NORMAL;
                cmd_o.load_simple = 1'b1;
                cmd_o.simple_kind = vtesc_pkg::KIND_TEXT;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NORMAL;
    end else begin
      state_q <= state_d;
    end
  end

  `VTESC_ASSERT_ALWAYS(a_reset_normal, !rst_ni |-> (state_q == ST_NORMAL), "state not normal in reset")
  `VTESC_ASSERT(a_read_then_push, (state_q == ST_EMIT_RD) |=> (state_q == ST_EMIT_PUSH), "parameter read not followed by push")
  `VTESC_ASSERT(a_final_starts_emit, cmd_o.close_param |=> (state_q == ST_EMIT_RD), "final char did not start parameter output")
  `VTESC_ASSERT(a_push_needs_room, cmd_o.emit_push |-> sts_i.out_free, "parameter pushed into a full output register")
  `VTESC_ASSERT(a_last_push_ends, (cmd_o.emit_push && sts_i.emit_last) |=> (state_q == ST_NORMAL), "last parameter did not end the sequence")

endmodule

// ===== design/vt_escape_sequence_parser.sv =====
// Top level of the VT escape sequence parser.
`timescale 1ns / 1ps

// Takes one received byte per item and gives classified events: text, ESC commands,
// ESC # commands, G0/G1 charset designations and CSI commands, the latter as one item per
// parameter in order with last set on the final one. A byte is accepted every cycle while
// the output register is free or being taken. The final character of a CSI sequence starts
// parameter output, which for each parameter does a registered read of the parameter
// memory, then the load of the output register, which waits out any output stall; no byte
// is accepted during that time.

module vt_escape_sequence_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  vtesc_in_if.sink     in_i,
  vtesc_out_if.source  out_o
);

  vtesc_pkg::vtesc_cmd_t cmd;
  vtesc_pkg::vtesc_sts_t sts;

  vtesc_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .ch_i       (in_i.ch),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vtesc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ch_i          (in_i.ch),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .kind_o        (out_o.kind),
    .code_o        (out_o.code),
    .intro_o       (out_o.intro),
    .param_count_o (out_o.param_count),
    .param_index_o (out_o.param_index),
    .param_value_o (out_o.param_value),
    .last_o        (out_o.last)
  );

endmodule

// ===== test/vt_escape_sequence_parser_tb.sv =====
// Self-checking testbench for the VT escape sequence parser, with a built-in event predictor.
`timescale 1ns / 1ps

module vt_escape_sequence_parser_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned RandomChars = 288;
  localparam int unsigned ShownErrors = 10;

  localparam logic [7:0] EscCmds [10] = '{
    vtesc_pkg::CH_LC_C, vtesc_pkg::CH_SEVEN, vtesc_pkg::CH_EIGHT, vtesc_pkg::CH_UC_H,
    vtesc_pkg::CH_UC_J, vtesc_pkg::CH_UC_K, vtesc_pkg::CH_UC_D, vtesc_pkg::CH_UC_E,
    vtesc_pkg::CH_UC_I, vtesc_pkg::CH_UC_M
  };
  localparam logic [7:0] HashCmds [5] = '{
    vtesc_pkg::CH_THREE, vtesc_pkg::CH_FOUR, vtesc_pkg::CH_FIVE, vtesc_pkg::CH_SIX,
    vtesc_pkg::CH_EIGHT
  };
  localparam logic [7:0] Designators [4] = '{
    vtesc_pkg::CH_LPAREN, vtesc_pkg::CH_RPAREN, vtesc_pkg::CH_PLUS, vtesc_pkg::CH_STAR
  };
  localparam logic [7:0] Controls [4] = '{
    vtesc_pkg::CH_BS, vtesc_pkg::CH_LF, vtesc_pkg::CH_CR, vtesc_pkg::CH_VT
  };
  localparam logic [7:0] NoiseChars [8] = '{
    vtesc_pkg::CH_ESC, vtesc_pkg::CH_VT, vtesc_pkg::CH_BS, vtesc_pkg::CH_LF,
    vtesc_pkg::CH_CR, vtesc_pkg::CH_LBRACKET, vtesc_pkg::CH_SEMI, vtesc_pkg::CH_HASH
  };

  typedef enum logic [2:0] {
    PM_NORMAL     = 3'd0,
    PM_ESC        = 3'd1,
    PM_CSI_START  = 3'd2,
    PM_CSI_PARAM  = 3'd3,
    PM_HASH       = 3'd4,
    PM_READ_CHAR  = 3'd5
  } parse_mode_e;

  typedef struct packed {
    logic [vtesc_pkg::KindW-1:0] kind;
    logic [7:0]                  code;
    logic [7:0]                  intro;
    logic [vtesc_pkg::CntW-1:0]  param_count;
    logic [vtesc_pkg::IdxW-1:0]  param_index;
    logic [7:0]                  param_value;
    logic                        last;
  } vt_event_t;

  logic clk_i;
  logic rst_ni;
  logic idle_on;
  logic out_hold;

  parse_mode_e                pm;
  logic [7:0]                 pm_intro;
  logic [vtesc_pkg::CntW-1:0] pm_count;
  logic [7:0]                 pm_params [vtesc_pkg::MaxParams];

  vt_event_t   events_due [$];
  int unsigned err_count;
  int unsigned chars_sent;
  int unsigned cycles;

  vtesc_in_if  in_if ();
  vtesc_out_if out_if ();

  vt_escape_sequence_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void queue_event(logic [vtesc_pkg::KindW-1:0] kind, logic [7:0] code,
                                      logic [7:0] intro = 8'd0,
                                      logic [vtesc_pkg::CntW-1:0] cnt = '0,
                                      logic [vtesc_pkg::IdxW-1:0] idx = '0,
                                      logic [7:0] val = 8'd0, logic last = 1'b1);
    vt_event_t ev;
    ev.kind        = kind;
    ev.code        = code;
    ev.intro       = intro;
    ev.param_count = cnt;
    ev.param_index = idx;
    ev.param_value = val;
    ev.last        = last;
    events_due.push_back(ev);
  endfunction

  // Advances the parser state by one byte and queues the events it causes.
  function automatic void parse_ch(logic [7:0] c);
    if (pm != PM_NORMAL && (c == vtesc_pkg::CH_BS || c == vtesc_pkg::CH_LF ||
                            c == vtesc_pkg::CH_CR)) begin
      queue_event(vtesc_pkg::KIND_TEXT, c);
      return;
    end
    if (pm != PM_NORMAL && c == vtesc_pkg::CH_VT) begin
      pm = PM_READ_CHAR;
      return;
    end
    case (pm)
      PM_ESC: begin
        pm = PM_NORMAL;
        if (c == vtesc_pkg::CH_LBRACKET) begin
          pm_intro     = 8'd0;
          pm_count     = vtesc_pkg::CntW'(1);
          pm_params[0] = 8'd0;
          pm           = PM_CSI_START;
        end else if (c == vtesc_pkg::CH_HASH) begin
          pm = PM_HASH;
        end else if (c == vtesc_pkg::CH_ESC) begin
          queue_event(vtesc_pkg::KIND_TEXT, c);
        end else if (c inside {EscCmds}) begin
          queue_event(vtesc_pkg::KIND_ESC, c);
        end else if (c inside {Designators}) begin
          pm_intro = c;
          pm       = PM_READ_CHAR;
        end
      end
      PM_CSI_START, PM_CSI_PARAM: begin
        if (c >= vtesc_pkg::CH_ZERO && c <= vtesc_pkg::CH_NINE) begin
          pm_params[pm_count - 1] = pm_params[pm_count - 1] * 8'd10 + (c - vtesc_pkg::CH_ZERO);
          pm = PM_CSI_PARAM;
        end else if (c == vtesc_pkg::CH_SEMI) begin
          pm_count = pm_count + vtesc_pkg::CntW'(1);
          if (pm_count > vtesc_pkg::MaxParams) begin
            pm = PM_NORMAL;
          end else begin
            pm_params[pm_count - 1] = 8'd0;
            pm = PM_CSI_PARAM;
          end
        end else if (pm == PM_CSI_START && (c == vtesc_pkg::CH_QUEST ||
                                            c == vtesc_pkg::CH_HASH)) begin
          pm_intro = c;
          pm       = PM_CSI_PARAM;
        end else begin
          pm = PM_NORMAL;
          for (int i = 0; i < pm_count; i++) begin
            queue_event(vtesc_pkg::KIND_CSI, c, pm_intro, pm_count, vtesc_pkg::IdxW'(i),
                        pm_params[i], i == pm_count - 1);
          end
        end
      end
      PM_HASH: begin
        pm = PM_NORMAL;
        if (c inside {HashCmds}) begin
          queue_event(vtesc_pkg::KIND_HASH, c);
        end
      end
      PM_READ_CHAR: begin
        pm = PM_NORMAL;
        if (pm_intro == vtesc_pkg::CH_LPAREN || pm_intro == vtesc_pkg::CH_RPAREN) begin
          queue_event(vtesc_pkg::KIND_CSET, c, pm_intro);
        end
      end
      default: begin
        if (c == vtesc_pkg::CH_ESC) begin
          pm = PM_ESC;
        end else begin
          pm = PM_NORMAL;
          queue_event(vtesc_pkg::KIND_TEXT, c);
        end
      end
    endcase
  endfunction

  task automatic send_ch(input logic [7:0] c);
    int gap;
    gap = (idle_on && $urandom_range(99) < 17) ? $urandom_range(3, 1) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk_i); while (!in_if.ready);
    parse_ch(c);
    chars_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_ch(s[i]);
    end
  endtask

  task automatic send_number(input int digits);
    for (int i = 0; i < digits; i++) begin
      send_ch(vtesc_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (events_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_sequence();
    int sel;
    int n;
    logic [7:0] c;
    sel = $urandom_range(99);
    if (sel < 25) begin
      repeat ($urandom_range(4, 1)) begin
        do c = 8'($urandom_range(255)); while (c == vtesc_pkg::CH_ESC);
        send_ch(c);
      end
    end else if (sel < 35) begin
      send_ch(vtesc_pkg::CH_ESC);
      send_ch(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : EscCmds[$urandom_range(9)]);
    end else if (sel < 42) begin
      send_ch(vtesc_pkg::CH_ESC);
      send_ch(vtesc_pkg::CH_HASH);
      send_ch(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : HashCmds[$urandom_range(4)]);
    end else if (sel < 52) begin
      send_ch(vtesc_pkg::CH_ESC);
      send_ch(Designators[$urandom_range(3)]);
      send_ch(8'($urandom_range(255)));
    end else if (sel < 85) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(vtesc_pkg::MaxParams + 1, 5)
                                   : $urandom_range(4, 1);
      send_ch(vtesc_pkg::CH_ESC);
      send_ch(vtesc_pkg::CH_LBRACKET);
      if ($urandom_range(2) == 0) begin
        send_ch($urandom_range(1) ? vtesc_pkg::CH_QUEST : vtesc_pkg::CH_HASH);
      end
      for (int p = 0; p < n; p++) begin
        if (p != 0) begin
          send_ch(vtesc_pkg::CH_SEMI);
        end
        send_number($urandom_range(3));
        if ($urandom_range(11) == 0) begin
          send_ch(Controls[$urandom_range(3)]);
        end
      end
      send_ch(8'($urandom_range(8'h7E, 8'h40)));
    end else begin
      repeat ($urandom_range(3, 1)) begin
        send_ch(($urandom_range(3) == 0) ? NoiseChars[$urandom_range(7)]
                                         : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_text_bytes();
    send_ch(8'h00);
    send_ch(8'hFF);
    send_ch(vtesc_pkg::CH_VT);
    wait_drain();
  endtask

  task automatic test_esc_commands();
    send_ch(vtesc_pkg::CH_ESC);
    send_ch(vtesc_pkg::CH_LC_C);
    send_ch(vtesc_pkg::CH_ESC);
    send_ch(vtesc_pkg::CH_ESC);
    send_ch(vtesc_pkg::CH_ESC);
    send_ch(vtesc_pkg::CH_HASH);
    send_ch(vtesc_pkg::CH_EIGHT);
    wait_drain();
  endtask

  task automatic test_charset_designation();
    send_ch(vtesc_pkg::CH_ESC);
    send_str("(B");
    // The intro is still '(', so VT after ESC makes the next byte a designation.
    send_ch(vtesc_pkg::CH_ESC);
    send_ch(vtesc_pkg::CH_VT);
    send_str("A");
    wait_drain();
  endtask

  task automatic test_csi_commands();
    send_ch(vtesc_pkg::CH_ESC);
    send_str("[?25;9");
    send_ch(vtesc_pkg::CH_LF);
    send_str("h");
    send_ch(vtesc_pkg::CH_ESC);
    send_str("[256m");
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    fork
      begin
        out_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_hold <= 1'b0;
      end
    join_none
    repeat (12) send_ch(8'($urandom_range(255, 128)));
    send_ch(vtesc_pkg::CH_ESC);
    send_ch(vtesc_pkg::CH_LBRACKET);
    for (int p = 0; p < vtesc_pkg::MaxParams; p++) begin
      if (p != 0) begin
        send_ch(vtesc_pkg::CH_SEMI);
      end
      send_number($urandom_range(3, 1));
    end
    send_str("r");
    wait_drain();
  endtask

  task automatic test_random_stream(input int unsigned n_chars);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      send_random_sequence();
    end
    wait_drain();
  endtask

  always @(posedge clk_i) begin
    vt_event_t got;
    vt_event_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.kind, out_if.code, out_if.intro, out_if.param_count,
              out_if.param_index, out_if.param_value, out_if.last};
      if (events_due.size() == 0) begin
        err_count++;
        if (err_count <= ShownErrors) begin
          $display("unexpected event: kind %0d code %h", got.kind, got.code);
        end
      end else begin
        exp = events_due.pop_front();
        if (got != exp) begin
          err_count++;
          if (err_count <= ShownErrors) begin
            $display("mismatch (expected/actual): kind %0d/%0d code %h/%h intro %h/%h",
                     exp.kind, got.kind, exp.code, got.code, exp.intro, got.intro);
            $display("  count %0d/%0d index %0d/%0d value %0d/%0d last %0b/%0b",
                     exp.param_count, got.param_count, exp.param_index, got.param_index,
                     exp.param_value, got.param_value, exp.last, got.last);
          end
        end
      end
    end
    out_if.ready <= rst_ni && !out_hold && !(idle_on && $urandom_range(99) < 25);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    idle_on      = 1'b1;
    out_hold     = 1'b0;
    in_if.valid  = 1'b0;
    in_if.ch     = 8'd0;
    out_if.ready = 1'b0;
    err_count    = 0;
    chars_sent   = 0;
    cycles       = 0;
    pm           = PM_NORMAL;
    pm_intro     = 8'd0;
    pm_count     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_text_bytes();
    test_esc_commands();
    test_charset_designation();
    test_csi_commands();
    test_output_backpressure();
    test_random_stream(RandomChars * 2 / 3);
    idle_on <= 1'b0;
    test_random_stream(RandomChars / 3);
    idle_on <= 1'b1;

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && events_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== vt_escape_sequence_parser.f =====
+incdir+design
design/vtesc_pkg.sv
design/vtesc_if.sv
design/vtesc_datapath.sv
design/vtesc_controller.sv
design/vt_escape_sequence_parser.sv
test/vt_escape_sequence_parser_tb.sv
